[rtl/timed_output_override_manager_defines.svh]
// Assertion macros shared by the timed output override manager RTL.
`ifndef TIMED_OUTPUT_OVERRIDE_MANAGER_DEFINES_SVH
`define TIMED_OUTPUT_OVERRIDE_MANAGER_DEFINES_SVH
`ifndef SYNTHESIS
`define TOOM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define TOOM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TOOM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define TOOM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/toom_pkg.sv]
// Types, codes and constants of the timed output override manager.
`default_nettype none
package toom_pkg;

   localparam logic [3:0] CMD_SET_OVR    = 4'd0;
   localparam logic [3:0] CMD_CLR_OVR    = 4'd1;
   localparam logic [3:0] CMD_CLR_ALL    = 4'd2;
   localparam logic [3:0] CMD_FEED_START = 4'd3;
   localparam logic [3:0] CMD_FEED_STOP  = 4'd4;
   localparam logic [3:0] CMD_SVC_START  = 4'd5;
   localparam logic [3:0] CMD_SVC_STOP   = 4'd6;
   localparam logic [3:0] CMD_RESOLVE    = 4'd7;
   localparam logic [3:0] CMD_OVR_SNAP   = 4'd8;
   localparam logic [3:0] CMD_MODE_SNAP  = 4'd9;
   localparam logic [3:0] CMD_RESET      = 4'd10;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_TGT  = 2'd1;
   localparam logic [1:0] ST_BAD_DUR  = 2'd2;
   localparam logic [1:0] ST_CONFLICT = 2'd3;

   localparam logic [2:0] CSR_OVR_MIN   = 3'd0;
   localparam logic [2:0] CSR_OVR_MAX   = 3'd1;
   localparam logic [2:0] CSR_FEED_MIN  = 3'd2;
   localparam logic [2:0] CSR_FEED_MAX  = 3'd3;
   localparam logic [2:0] CSR_SVC_MIN   = 3'd4;
   localparam logic [2:0] CSR_SVC_MAX   = 3'd5;
   localparam logic [2:0] CSR_FEED_MASK = 3'd6;

   localparam logic [19:0] RST_OVR_MIN   = 20'd1;
   localparam logic [19:0] RST_OVR_MAX   = 20'd3600;
   localparam logic [19:0] RST_FEED_MIN  = 20'd1;
   localparam logic [19:0] RST_FEED_MAX  = 20'd900;
   localparam logic [19:0] RST_SVC_MIN   = 20'd1;
   localparam logic [19:0] RST_SVC_MAX   = 20'd3600;
   localparam logic [6:0]  RST_FEED_MASK = 7'd100;

   localparam logic [31:0] MS_PER_S    = 32'd1000;
   localparam logic [31:0] ROUND_UP_MS = 32'd999;
   // Multiplying by this and shifting right by DIV_SHIFT divides a 32-bit value by 1000.
   localparam logic [31:0] RECIP_1000  = 32'd2199023256;
   localparam int          DIV_SHIFT   = 41;
   localparam logic [19:0] MAX_SECS    = 20'hFFFFF;

   typedef struct packed {
      logic [1:0]  status;
      logic        drive;
      logic        managed;
      logic        ovr_active;
      logic        ovr_level;
      logic [19:0] ovr_left_s;
      logic        feed_active;
      logic [19:0] feed_left_s;
      logic        service_active;
      logic [19:0] service_left_s;
   } rsp_type;

   function automatic logic is_live(input logic [31:0] diff);
      return (diff != 32'd0) && !diff[31];
   endfunction

endpackage
`default_nettype wire

[rtl/toom_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module toom_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[rtl/timed_output_override_manager.sv]
// Top level of the timed output override manager.
//
// A request on the req_ channel carries one command with the current time in
// milliseconds; every request yields exactly one response on the rsp_ channel.
// The block takes one request at a time: req_stall is low only while the
// sequencer is idle. Commands that expire timers first sweep every channel
// deadline and then the feeding and service deadlines through one shared
// subtractor. For an override or mode snapshot, each remaining-seconds value
// then passes through subtract, multiply and scale steps.
// The response sits in an output register, so the next request can be taken
// while the receiver stalls; a finished command then waits until that
// register is free. Synchronous reset clears all timers and overrides and
// restores the csr_ registers to their defaults; the csr_ port must be
// written only while the block is idle.
`default_nettype none
`include "timed_output_override_manager_defines.svh"
module timed_output_override_manager
   import toom_pkg::*;
#(
   parameter int NUM_CHANNELS = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_cmd,
   input  wire logic [2:0]  req_target,
   input  wire logic        req_on_request,
   input  wire logic [19:0] req_duration_s,
   input  wire logic        req_auto_level,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             rsp_drive,
   output logic             rsp_managed,
   output logic             rsp_ovr_active,
   output logic             rsp_ovr_level,
   output logic [19:0]      rsp_ovr_left_s,
   output logic             rsp_feed_active,
   output logic [19:0]      rsp_feed_left_s,
   output logic             rsp_service_active,
   output logic [19:0]      rsp_service_left_s,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);

   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CW = $clog2(NUM_CHANNELS + 3);
   localparam logic [CW-1:0] LAPSE_CH_END = CW'(NUM_CHANNELS);
   localparam logic [CW-1:0] LAPSE_FEED   = CW'(NUM_CHANNELS + 1);
   localparam logic [CW-1:0] LAPSE_LAST   = CW'(NUM_CHANNELS + 2);
   localparam int QW = 64 - DIV_SHIFT;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LAPSE = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_SUB   = 3'd4;
   localparam logic [2:0] S_MUL   = 3'd5;
   localparam logic [2:0] S_QUO   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic [1:0] SEL_OVR  = 2'd0;
   localparam logic [1:0] SEL_FEED = 2'd1;
   localparam logic [1:0] SEL_SVC  = 2'd2;

   logic [2:0]              state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [1:0]              sel_ff, sel_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NUM_CHANNELS-1:0] ovr_on_ff, ovr_on_in;
   logic [NUM_CHANNELS-1:0] ovr_val_ff, ovr_val_in;
   logic                    feed_on_ff, feed_on_in;
   logic                    svc_on_ff, svc_on_in;
   logic [19:0]             ovr_min_ff, ovr_min_in;
   logic [19:0]             ovr_max_ff, ovr_max_in;
   logic [19:0]             feed_min_ff, feed_min_in;
   logic [19:0]             feed_max_ff, feed_max_in;
   logic [19:0]             svc_min_ff, svc_min_in;
   logic [19:0]             svc_max_ff, svc_max_in;
   logic [6:0]              feed_mask_ff, feed_mask_in;

   logic [3:0]              cmd_ff, cmd_in;
   logic [2:0]              tgt_ff, tgt_in;
   logic                    onreq_ff, onreq_in;
   logic [19:0]             dur_ff, dur_in;
   logic                    auto_ff, auto_in;
   logic [31:0]             now_ff, now_in;
   logic [31:0]             feed_dl_ff, feed_dl_in;
   logic [31:0]             svc_dl_ff, svc_dl_in;
   logic [31:0]             num_ff, num_in;
   logic                    live_ff, live_in;
   logic [63:0]             prod_ff, prod_in;
   rsp_type                 res_ff, res_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    ram_we;
   logic [AW-1:0]           ram_raddr;
   logic [31:0]             ram_rdata;

   logic [AW-1:0]           tgt_idx;
   logic [CW-1:0]           lap_dec;
   logic [AW-1:0]           lap_idx;
   logic [31:0]             op;
   logic [31:0]             diff;
   logic                    live;
   logic [31:0]             dl_new;
   logic                    tgt_ok;
   logic [7:0]              mask_ext;
   logic [QW-1:0]           quo;
   logic [19:0]             secs;
   logic                    act;

   assign tgt_idx  = AW'(tgt_ff);
   assign lap_dec  = cnt_ff - CW'(1);
   assign lap_idx  = lap_dec[AW-1:0];
   assign tgt_ok   = 32'(tgt_ff) < NUM_CHANNELS;
   assign mask_ext = {1'b0, feed_mask_ff};
   assign dl_new   = now_ff + (32'(dur_ff) * MS_PER_S);
   assign quo      = prod_ff[63:DIV_SHIFT];
   assign secs     = (quo > QW'(MAX_SECS)) ? MAX_SECS : quo[19:0];

   always_comb begin
      if (state_ff == S_LAPSE) begin
         if (cnt_ff == LAPSE_FEED) begin
            op = feed_dl_ff;
         end else if (cnt_ff == LAPSE_LAST) begin
            op = svc_dl_ff;
         end else begin
            op = ram_rdata;
         end
      end else begin
         case (sel_ff)
            SEL_FEED: op = feed_dl_ff;
            SEL_SVC:  op = svc_dl_ff;
            default:  op = ram_rdata;
         endcase
      end
   end

   assign diff = op - now_ff;
   assign live = is_live(diff);

   always_comb begin
      case (sel_ff)
         SEL_FEED: act = feed_on_ff;
         SEL_SVC:  act = svc_on_ff;
         default:  act = ovr_on_ff[tgt_idx];
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      ovr_on_in    = ovr_on_ff;
      ovr_val_in   = ovr_val_ff;
      feed_on_in   = feed_on_ff;
      svc_on_in    = svc_on_ff;
      ovr_min_in   = ovr_min_ff;
      ovr_max_in   = ovr_max_ff;
      feed_min_in  = feed_min_ff;
      feed_max_in  = feed_max_ff;
      svc_min_in   = svc_min_ff;
      svc_max_in   = svc_max_ff;
      feed_mask_in = feed_mask_ff;
      cmd_in       = cmd_ff;
      tgt_in       = tgt_ff;
      onreq_in     = onreq_ff;
      dur_in       = dur_ff;
      auto_in      = auto_ff;
      now_in       = now_ff;
      feed_dl_in   = feed_dl_ff;
      svc_dl_in    = svc_dl_ff;
      num_in       = num_ff;
      live_in      = live_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_raddr    = tgt_idx;

      if (csr_we) begin
         case (csr_index)
            CSR_OVR_MIN:   ovr_min_in   = csr_wdata;
            CSR_OVR_MAX:   ovr_max_in   = csr_wdata;
            CSR_FEED_MIN:  feed_min_in  = csr_wdata;
            CSR_FEED_MAX:  feed_max_in  = csr_wdata;
            CSR_SVC_MIN:   svc_min_in   = csr_wdata;
            CSR_SVC_MAX:   svc_max_in   = csr_wdata;
            CSR_FEED_MASK: feed_mask_in = csr_wdata[6:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               tgt_in   = req_target;
               onreq_in = req_on_request;
               dur_in   = req_duration_s;
               auto_in  = req_auto_level;
               now_in   = req_now_ms;
               res_in   = '0;
               cnt_in   = '0;
               sel_in   = SEL_OVR;
               if (req_cmd inside {CMD_SET_OVR, CMD_FEED_START, CMD_SVC_START,
                                   CMD_RESOLVE, CMD_OVR_SNAP, CMD_MODE_SNAP}) begin
                  state_in = S_LAPSE;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_LAPSE: begin
            ram_raddr = (cnt_ff < LAPSE_CH_END) ? cnt_ff[AW-1:0] : '0;
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff != '0 && cnt_ff <= LAPSE_CH_END && !live) begin
               ovr_on_in[lap_idx] = 1'b0;
            end
            if (cnt_ff == LAPSE_FEED && !live) begin
               feed_on_in = 1'b0;
            end
            if (cnt_ff == LAPSE_LAST) begin
               if (!live) begin
                  svc_on_in = 1'b0;
               end
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (cmd_ff)
               CMD_SET_OVR: begin
                  if (!tgt_ok) begin
                     res_in.status = ST_BAD_TGT;
                  end else if (dur_ff < ovr_min_ff || dur_ff > ovr_max_ff) begin
                     res_in.status = ST_BAD_DUR;
                  end else if (svc_on_ff) begin
                     res_in.status = ST_CONFLICT;
                  end else begin
                     ovr_on_in[tgt_idx]  = 1'b1;
                     ovr_val_in[tgt_idx] = onreq_ff;
                     ram_we              = 1'b1;
                  end
               end
               CMD_CLR_OVR: begin
                  if (!tgt_ok) begin
                     res_in.status = ST_BAD_TGT;
                  end else begin
                     ovr_on_in[tgt_idx] = 1'b0;
                  end
               end
               CMD_CLR_ALL: begin
                  ovr_on_in = '0;
               end
               CMD_FEED_START: begin
                  if (dur_ff < feed_min_ff || dur_ff > feed_max_ff) begin
                     res_in.status = ST_BAD_DUR;
                  end else if (svc_on_ff) begin
                     res_in.status = ST_CONFLICT;
                  end else begin
                     feed_on_in = 1'b1;
                     feed_dl_in = dl_new;
                  end
               end
               CMD_FEED_STOP: begin
                  feed_on_in = 1'b0;
               end
               CMD_SVC_START: begin
                  if (dur_ff < svc_min_ff || dur_ff > svc_max_ff) begin
                     res_in.status = ST_BAD_DUR;
                  end else begin
                     feed_on_in = 1'b0;
                     ovr_on_in  = '0;
                     svc_on_in  = 1'b1;
                     svc_dl_in  = dl_new;
                  end
               end
               CMD_SVC_STOP: begin
                  svc_on_in = 1'b0;
               end
               CMD_RESOLVE: begin
                  res_in.drive   = auto_ff;
                  res_in.managed = 1'b0;
                  if (!tgt_ok) begin
                     res_in.status = ST_BAD_TGT;
                  end else if (svc_on_ff || (feed_on_ff && mask_ext[tgt_ff])) begin
                     res_in.drive   = 1'b0;
                     res_in.managed = 1'b1;
                  end else if (ovr_on_ff[tgt_idx]) begin
                     res_in.drive   = ovr_val_ff[tgt_idx];
                     res_in.managed = 1'b1;
                  end
               end
               CMD_OVR_SNAP: begin
                  if (!tgt_ok) begin
                     res_in.status = ST_BAD_TGT;
                  end else begin
                     res_in.ovr_active = ovr_on_ff[tgt_idx];
                     res_in.ovr_level  = ovr_val_ff[tgt_idx];
                     sel_in            = SEL_OVR;
                     state_in          = S_SUB;
                  end
               end
               CMD_MODE_SNAP: begin
                  res_in.feed_active    = feed_on_ff;
                  res_in.service_active = svc_on_ff;
                  sel_in                = SEL_FEED;
                  state_in              = S_SUB;
               end
               CMD_RESET: begin
                  ovr_on_in  = '0;
                  ovr_val_in = '0;
                  feed_on_in = 1'b0;
                  feed_dl_in = '0;
                  svc_on_in  = 1'b0;
                  svc_dl_in  = '0;
               end
               default: ;
            endcase
         end
         S_SUB: begin
            num_in   = diff + ROUND_UP_MS;
            live_in  = live;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = 64'(num_ff) * 64'(RECIP_1000);
            state_in = S_QUO;
         end
         S_QUO: begin
            case (sel_ff)
               SEL_FEED: begin
                  res_in.feed_left_s = (act && live_ff) ? secs : '0;
                  sel_in             = SEL_SVC;
                  state_in           = S_SUB;
               end
               SEL_SVC: begin
                  res_in.service_left_s = (act && live_ff) ? secs : '0;
                  state_in              = S_DONE;
               end
               default: begin
                  res_in.ovr_left_s = (act && live_ff) ? secs : '0;
                  state_in          = S_DONE;
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= SEL_OVR;
         rsp_valid_ff <= 1'b0;
         ovr_on_ff    <= '0;
         ovr_val_ff   <= '0;
         feed_on_ff   <= 1'b0;
         svc_on_ff    <= 1'b0;
         ovr_min_ff   <= RST_OVR_MIN;
         ovr_max_ff   <= RST_OVR_MAX;
         feed_min_ff  <= RST_FEED_MIN;
         feed_max_ff  <= RST_FEED_MAX;
         svc_min_ff   <= RST_SVC_MIN;
         svc_max_ff   <= RST_SVC_MAX;
         feed_mask_ff <= RST_FEED_MASK;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
         ovr_on_ff    <= ovr_on_in;
         ovr_val_ff   <= ovr_val_in;
         feed_on_ff   <= feed_on_in;
         svc_on_ff    <= svc_on_in;
         ovr_min_ff   <= ovr_min_in;
         ovr_max_ff   <= ovr_max_in;
         feed_min_ff  <= feed_min_in;
         feed_max_ff  <= feed_max_in;
         svc_min_ff   <= svc_min_in;
         svc_max_ff   <= svc_max_in;
         feed_mask_ff <= feed_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      tgt_ff     <= tgt_in;
      onreq_ff   <= onreq_in;
      dur_ff     <= dur_in;
      auto_ff    <= auto_in;
      now_ff     <= now_in;
      feed_dl_ff <= feed_dl_in;
      svc_dl_ff  <= svc_dl_in;
      num_ff     <= num_in;
      live_ff    <= live_in;
      prod_ff    <= prod_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   toom_ram #(
      .WIDTH (32),
      .DEPTH (NUM_CHANNELS)
   ) u_deadline_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (tgt_idx),
      .wdata (dl_new),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_drive          = rsp_ff.drive;
   assign rsp_managed        = rsp_ff.managed;
   assign rsp_ovr_active     = rsp_ff.ovr_active;
   assign rsp_ovr_level      = rsp_ff.ovr_level;
   assign rsp_ovr_left_s     = rsp_ff.ovr_left_s;
   assign rsp_feed_active    = rsp_ff.feed_active;
   assign rsp_feed_left_s    = rsp_ff.feed_left_s;
   assign rsp_service_active = rsp_ff.service_active;
   assign rsp_service_left_s = rsp_ff.service_left_s;

   // Service mode excludes feeding and every override.
   `TOOM_ASSERT_IMPLY(a_svc_exclusive, clock, reset, svc_on_ff, (ovr_on_ff == '0) && !feed_on_ff, "service active alongside feeding or override")
   `TOOM_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, (state_ff == S_LAPSE) || (state_ff == S_EXEC), "accepted request did not start")
   `TOOM_ASSERT_IMPLY(a_lapse_bound, clock, reset, state_ff == S_LAPSE, cnt_ff <= LAPSE_LAST, "expiry sweep overran")
   `TOOM_ASSERT_NEXT(a_done_handoff, clock, reset, (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall), rsp_valid_ff && (state_ff == S_IDLE), "finished command not handed to response")

endmodule
`default_nettype wire

[tb/timed_output_override_manager_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the timed output override manager command interface.
module timed_output_override_manager_test
   import toom_pkg::*;
();

   localparam int CHANNELS = 7;
   localparam int SETTLE_CYCLES = 24;
   localparam int QUIET_LIMIT = 5000;
   localparam logic [3:0] CMD_UNUSED_TOP = 4'd15;

   typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_cmd = '0;
   logic [2:0] req_target = '0;
   logic req_on_request = 1'b0;
   logic [19:0] req_duration_s = '0;
   logic req_auto_level = 1'b0;
   logic [31:0] req_now_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic rsp_drive;
   logic rsp_managed;
   logic rsp_ovr_active;
   logic rsp_ovr_level;
   logic [19:0] rsp_ovr_left_s;
   logic rsp_feed_active;
   logic [19:0] rsp_feed_left_s;
   logic rsp_service_active;
   logic [19:0] rsp_service_left_s;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [19:0] csr_wdata = '0;

   logic [19:0] lim_ovr_lo, lim_ovr_hi, lim_feed_lo, lim_feed_hi, lim_svc_lo, lim_svc_hi;
   logic [6:0] feed_mask;
   logic [CHANNELS-1:0] chan_hold, chan_level;
   logic [31:0] chan_due [CHANNELS];
   logic feed_run, svc_run;
   logic [31:0] feed_due, svc_due;

   rsp_type owed_responses [$];
   logic [31:0] wall_ms = '0;
   int fault_count = 0;
   int burst_left = 0;
   bit steady_feed = 0;
   rx_mode_type rx_mode = RX_OPEN;
   int rx_left = 0;
   int quiet_cycles = 0;

   timed_output_override_manager #(.NUM_CHANNELS(CHANNELS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_target(req_target),
      .req_on_request(req_on_request),
      .req_duration_s(req_duration_s),
      .req_auto_level(req_auto_level),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_drive(rsp_drive),
      .rsp_managed(rsp_managed),
      .rsp_ovr_active(rsp_ovr_active),
      .rsp_ovr_level(rsp_ovr_level),
      .rsp_ovr_left_s(rsp_ovr_left_s),
      .rsp_feed_active(rsp_feed_active),
      .rsp_feed_left_s(rsp_feed_left_s),
      .rsp_service_active(rsp_service_active),
      .rsp_service_left_s(rsp_service_left_s),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic timer_live(input logic [31:0] due, input logic [31:0] now);
      logic [31:0] gap;
      gap = due - now;
      return (gap != 32'd0) && !gap[31];
   endfunction

   function automatic logic [19:0] secs_remaining(input logic [31:0] due,
         input logic [31:0] now);
      logic [31:0] secs;
      if (!timer_live(due, now)) return '0;
      secs = ((due - now) + ROUND_UP_MS) / MS_PER_S;
      return (secs > MAX_SECS) ? MAX_SECS : secs[19:0];
   endfunction

   function automatic void clear_timers();
      chan_hold = '0;
      chan_level = '0;
      for (int c = 0; c < CHANNELS; c++) chan_due[c] = '0;
      feed_run = 1'b0;
      feed_due = '0;
      svc_run = 1'b0;
      svc_due = '0;
   endfunction

   function automatic void restore_defaults();
      lim_ovr_lo = RST_OVR_MIN;
      lim_ovr_hi = RST_OVR_MAX;
      lim_feed_lo = RST_FEED_MIN;
      lim_feed_hi = RST_FEED_MAX;
      lim_svc_lo = RST_SVC_MIN;
      lim_svc_hi = RST_SVC_MAX;
      feed_mask = RST_FEED_MASK;
      clear_timers();
   endfunction

   function automatic void expire_timers(input logic [31:0] now);
      for (int c = 0; c < CHANNELS; c++)
         if (chan_hold[c] && !timer_live(chan_due[c], now)) chan_hold[c] = 1'b0;
      if (feed_run && !timer_live(feed_due, now)) feed_run = 1'b0;
      if (svc_run && !timer_live(svc_due, now)) svc_run = 1'b0;
   endfunction

   function automatic rsp_type command_response(input logic [3:0] cmd, input logic [2:0] tgt,
         input logic lvl, input logic [19:0] dur, input logic auto_lvl,
         input logic [31:0] now);
      rsp_type r;
      logic [31:0] due;
      logic tgt_ok;
      r = '0;
      due = now + dur * MS_PER_S;
      tgt_ok = (tgt < CHANNELS);
      case (cmd)
         CMD_SET_OVR, CMD_FEED_START, CMD_SVC_START, CMD_RESOLVE, CMD_OVR_SNAP,
               CMD_MODE_SNAP: begin
            expire_timers(now);
         end
         default: ;
      endcase
      case (cmd)
         CMD_SET_OVR: begin
            if (!tgt_ok) r.status = ST_BAD_TGT;
            else if (dur < lim_ovr_lo || dur > lim_ovr_hi) r.status = ST_BAD_DUR;
            else if (svc_run) r.status = ST_CONFLICT;
            else begin
               chan_hold[tgt] = 1'b1;
               chan_level[tgt] = lvl;
               chan_due[tgt] = due;
            end
         end
         CMD_CLR_OVR: begin
            if (!tgt_ok) r.status = ST_BAD_TGT;
            else chan_hold[tgt] = 1'b0;
         end
         CMD_CLR_ALL: chan_hold = '0;
         CMD_FEED_START: begin
            if (dur < lim_feed_lo || dur > lim_feed_hi) r.status = ST_BAD_DUR;
            else if (svc_run) r.status = ST_CONFLICT;
            else begin
               feed_run = 1'b1;
               feed_due = due;
            end
         end
         CMD_FEED_STOP: feed_run = 1'b0;
         CMD_SVC_START: begin
            if (dur < lim_svc_lo || dur > lim_svc_hi) r.status = ST_BAD_DUR;
            else begin
               feed_run = 1'b0;
               chan_hold = '0;
               svc_run = 1'b1;
               svc_due = due;
            end
         end
         CMD_SVC_STOP: svc_run = 1'b0;
         CMD_RESOLVE: begin
            r.drive = auto_lvl;
            if (!tgt_ok) r.status = ST_BAD_TGT;
            else if (svc_run) begin
               r.drive = 1'b0;
               r.managed = 1'b1;
            end else if (feed_run && feed_mask[tgt]) begin
               r.drive = 1'b0;
               r.managed = 1'b1;
            end else if (chan_hold[tgt]) begin
               r.drive = chan_level[tgt];
               r.managed = 1'b1;
            end
         end
         CMD_OVR_SNAP: begin
            if (!tgt_ok) r.status = ST_BAD_TGT;
            else begin
               r.ovr_active = chan_hold[tgt];
               r.ovr_level = chan_level[tgt];
               r.ovr_left_s = chan_hold[tgt] ? secs_remaining(chan_due[tgt], now) : '0;
            end
         end
         CMD_MODE_SNAP: begin
            r.feed_active = feed_run;
            r.feed_left_s = feed_run ? secs_remaining(feed_due, now) : '0;
            r.service_active = svc_run;
            r.service_left_s = svc_run ? secs_remaining(svc_due, now) : '0;
         end
         CMD_RESET: clear_timers();
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_req(input logic [3:0] cmd, input logic [2:0] tgt, input logic lvl,
         input logic [19:0] dur, input logic auto_lvl, input logic [31:0] now);
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_target <= tgt;
      req_on_request <= lvl;
      req_duration_s <= dur;
      req_auto_level <= auto_lvl;
      req_now_ms <= now;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      owed_responses.push_back(command_response(cmd, tgt, lvl, dur, auto_lvl, now));
      if (!steady_feed) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_OVR_MIN: lim_ovr_lo = val;
         CSR_OVR_MAX: lim_ovr_hi = val;
         CSR_FEED_MIN: lim_feed_lo = val;
         CSR_FEED_MAX: lim_feed_hi = val;
         CSR_SVC_MIN: lim_svc_lo = val;
         CSR_SVC_MAX: lim_svc_hi = val;
         CSR_FEED_MASK: feed_mask = val[6:0];
         default: ;
      endcase
   endtask

   task automatic load_limits(input logic [19:0] ovr_lo, input logic [19:0] ovr_hi,
         input logic [19:0] feed_lo, input logic [19:0] feed_hi, input logic [19:0] svc_lo,
         input logic [19:0] svc_hi, input logic [19:0] mask);
      settle();
      write_reg(CSR_OVR_MIN, ovr_lo);
      write_reg(CSR_OVR_MAX, ovr_hi);
      write_reg(CSR_FEED_MIN, feed_lo);
      write_reg(CSR_FEED_MAX, feed_hi);
      write_reg(CSR_SVC_MIN, svc_lo);
      write_reg(CSR_SVC_MAX, svc_hi);
      write_reg(CSR_FEED_MASK, mask);
   endtask

   function automatic logic [19:0] pick_duration(input logic [19:0] lo, input logic [19:0] hi);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60 && lo <= hi) return 20'($urandom_range(hi, lo));
      else if (pick < 68) return lo;
      else if (pick < 76) return hi;
      else if (pick < 82) return lo - 20'd1;
      else if (pick < 88) return hi + 20'd1;
      else if (pick < 92) return '0;
      return 20'($urandom);
   endfunction

   // Mostly small steps forward, with landings on or next to stored deadlines and jumps both ways.
   function automatic logic [31:0] advance_clock();
      int pick;
      int sel;
      pick = $urandom_range(0, 99);
      if (pick < 7) return wall_ms;
      if (pick < 60) wall_ms = wall_ms + $urandom_range(0, 5000);
      else if (pick < 78) wall_ms = wall_ms + $urandom_range(0, 300000);
      else if (pick < 84) wall_ms = wall_ms - $urandom_range(1, 5000);
      else if (pick < 93) begin
         sel = $urandom_range(0, 2);
         if (sel == 0) wall_ms = chan_due[3'($urandom_range(0, CHANNELS - 1))];
         else if (sel == 1) wall_ms = feed_due;
         else wall_ms = svc_due;
         wall_ms = wall_ms + $urandom_range(0, 2) - 1;
      end else if (pick < 97) wall_ms = wall_ms + $urandom_range(0, 4000000);
      else wall_ms = $urandom;
      return wall_ms;
   endfunction

   task automatic random_request();
      int pick;
      logic [3:0] cmd;
      logic [2:0] tgt;
      logic [19:0] dur;
      pick = $urandom_range(0, 99);
      if (pick < 22) cmd = CMD_SET_OVR;
      else if (pick < 27) cmd = CMD_CLR_OVR;
      else if (pick < 29) cmd = CMD_CLR_ALL;
      else if (pick < 37) cmd = CMD_FEED_START;
      else if (pick < 41) cmd = CMD_FEED_STOP;
      else if (pick < 45) cmd = CMD_SVC_START;
      else if (pick < 50) cmd = CMD_SVC_STOP;
      else if (pick < 68) cmd = CMD_RESOLVE;
      else if (pick < 80) cmd = CMD_OVR_SNAP;
      else if (pick < 90) cmd = CMD_MODE_SNAP;
      else if (pick < 92) cmd = CMD_RESET;
      else if (pick < 94) cmd = 4'($urandom_range(CMD_UNUSED_TOP, CMD_RESET + 1));
      else cmd = 4'($urandom_range(0, CMD_UNUSED_TOP));
      if ($urandom_range(0, 9) == 0) tgt = '1;
      else tgt = 3'($urandom_range(0, CHANNELS - 1));
      case (cmd)
         CMD_FEED_START: dur = pick_duration(lim_feed_lo, lim_feed_hi);
         CMD_SVC_START: dur = pick_duration(lim_svc_lo, lim_svc_hi);
         default: dur = pick_duration(lim_ovr_lo, lim_ovr_hi);
      endcase
      send_req(cmd, tgt, 1'($urandom_range(0, 1)), dur, 1'($urandom_range(0, 1)),
            advance_clock());
   endtask

   task automatic run_random(input int count);
      steady_feed = ($urandom_range(0, 3) == 0);
      repeat (count) random_request();
      steady_feed = 0;
   endtask

   task automatic test_override_commands();
      wall_ms = 32'd1000;
      send_req(CMD_SET_OVR, '1, 1'b1, 20'd10, 1'b0, wall_ms);
      send_req(CMD_SET_OVR, 3'd0, 1'b1, lim_ovr_hi + 20'd1, 1'b0, wall_ms);
      send_req(CMD_SET_OVR, 3'd0, 1'b1, lim_ovr_lo - 20'd1, 1'b0, wall_ms);
      send_req(CMD_SET_OVR, 3'd6, 1'b1, lim_ovr_hi, 1'b0, wall_ms);
      send_req(CMD_OVR_SNAP, 3'd6, 1'b0, '0, 1'b0, wall_ms + 32'd1);
      send_req(CMD_RESOLVE, 3'd6, 1'b0, '0, 1'b0, wall_ms + lim_ovr_hi * MS_PER_S - 32'd1);
      send_req(CMD_OVR_SNAP, 3'd6, 1'b0, '0, 1'b0, wall_ms + lim_ovr_hi * MS_PER_S);
      send_req(CMD_CLR_OVR, '1, 1'b0, '0, 1'b0, wall_ms);
      send_req(CMD_CLR_OVR, 3'd0, 1'b0, '0, 1'b0, wall_ms);
      send_req(CMD_CLR_ALL, 3'd0, 1'b0, '0, 1'b0, wall_ms);
      send_req(CMD_OVR_SNAP, '1, 1'b0, '0, 1'b0, wall_ms);
      send_req(CMD_RESOLVE, '1, 1'b0, '0, 1'b1, wall_ms);
   endtask

   // Starts just below the wrap of the millisecond counter.
   task automatic test_mode_commands();
      wall_ms = 32'hFFFF_FC00;
      send_req(CMD_FEED_START, 3'd0, 1'b0, lim_feed_hi + 20'd1, 1'b0, wall_ms);
      send_req(CMD_FEED_START, 3'd0, 1'b0, lim_feed_hi, 1'b0, wall_ms);
      send_req(CMD_RESOLVE, 3'd2, 1'b0, '0, 1'b1, wall_ms + 32'd500);
      send_req(CMD_MODE_SNAP, 3'd0, 1'b0, '0, 1'b0, wall_ms + 32'd2000);
      send_req(CMD_SVC_START, 3'd0, 1'b0, lim_svc_hi, 1'b0, wall_ms + 32'd3000);
      send_req(CMD_SET_OVR, 3'd0, 1'b1, lim_ovr_lo, 1'b0, wall_ms + 32'd3000);
      send_req(CMD_FEED_START, 3'd0, 1'b0, lim_feed_lo, 1'b0, wall_ms + 32'd3000);
      send_req(CMD_SVC_STOP, 3'd0, 1'b0, '0, 1'b0, wall_ms + 32'd3000);
      send_req(CMD_FEED_STOP, 3'd0, 1'b0, '0, 1'b0, wall_ms + 32'd3000);
      send_req(CMD_RESET, 3'd0, 1'b0, '0, 1'b0, wall_ms + 32'd3000);
   endtask

   task automatic test_unused_codes();
      send_req(CMD_UNUSED_TOP, '1, 1'b1, '1, 1'b1, '1);
   endtask

   // A large step back makes the remaining count saturate.
   task automatic test_backward_clock();
      wall_ms = 32'h9000_0000;
      send_req(CMD_SET_OVR, 3'd4, 1'b1, lim_ovr_hi, 1'b0, wall_ms);
      send_req(CMD_OVR_SNAP, 3'd4, 1'b0, '0, 1'b0, wall_ms - 32'h7000_0000);
   endtask

   task automatic test_default_limits();
      load_limits(RST_OVR_MIN, RST_OVR_MAX, RST_FEED_MIN, RST_FEED_MAX, RST_SVC_MIN,
            RST_SVC_MAX, {13'd0, RST_FEED_MASK});
      run_random(150);
   endtask

   task automatic test_widest_limits();
      load_limits('0, '1, '0, '1, '0, '1, 20'h0007F);
      run_random(100);
   endtask

   task automatic test_zero_limits();
      load_limits('0, '0, '0, '0, '0, '0, '0);
      run_random(70);
   endtask

   task automatic test_top_limits();
      load_limits('1, '1, '1, '1, '1, '1, 20'($urandom));
      run_random(60);
   endtask

   task automatic test_random_limits();
      repeat (3) begin
         load_limits(20'($urandom_range(0, 600)), 20'($urandom_range(400, 5000)),
               20'($urandom_range(0, 300)), 20'($urandom_range(200, 1500)),
               20'($urandom_range(0, 600)), 20'($urandom_range(300, 5000)),
               20'($urandom));
         run_random(70);
      end
   endtask

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_mode)
         RX_OPEN: rsp_stall <= 1'b0;
         RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   task automatic compare_field(input string name, input logic [19:0] want,
         input logic [19:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin : check_response
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (owed_responses.size() == 0) begin
            $display("%0t: response mismatch, expected no response, actual status %0d",
                  $time, rsp_status);
            fault_count++;
         end else begin
            want = owed_responses.pop_front();
            compare_field("status", 20'(want.status), 20'(rsp_status));
            compare_field("drive", 20'(want.drive), 20'(rsp_drive));
            compare_field("managed", 20'(want.managed), 20'(rsp_managed));
            compare_field("ovr_active", 20'(want.ovr_active), 20'(rsp_ovr_active));
            compare_field("ovr_level", 20'(want.ovr_level), 20'(rsp_ovr_level));
            compare_field("ovr_left_s", want.ovr_left_s, rsp_ovr_left_s);
            compare_field("feed_active", 20'(want.feed_active), 20'(rsp_feed_active));
            compare_field("feed_left_s", want.feed_left_s, rsp_feed_left_s);
            compare_field("service_active", 20'(want.service_active),
                  20'(rsp_service_active));
            compare_field("service_left_s", want.service_left_s, rsp_service_left_s);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      restore_defaults();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_override_commands();
      test_mode_commands();
      test_unused_codes();
      test_backward_clock();
      test_default_limits();
      test_widest_limits();
      test_zero_limits();
      test_top_limits();
      test_random_limits();
      settle();
      if (fault_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/toom_pkg.sv
rtl/toom_ram.sv
rtl/timed_output_override_manager.sv
tb/timed_output_override_manager_test.sv
